FILE: hdl/plmpa_pkg.sv
`default_nettype none

package plmpa_pkg;

   // Field widths of the stream words.
   localparam int OP_W     = 2;
   localparam int LABEL_W  = 10;
   localparam int CELLS_W  = 20;
   localparam int AREA_W   = 52;
   localparam int NF_W     = 11;
   localparam int SCALAR_W = 32;
   localparam int CSR_IDX_W = 8;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 88;

   // Operation codes carried in req_tuser.
   localparam logic [OP_W-1:0] OP_CELL  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FEATURES = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_SCALAR  = 8'd1;

   localparam logic [NF_W-1:0]     NUM_FEATURES_RST = 11'd1024;
   localparam logic [SCALAR_W-1:0] AREA_SCALAR_RST  = 32'd65536;

endpackage

`default_nettype wire

FILE: hdl/per_label_max_plane_area.sv
`default_nettype none
// A cell word whose label is counted is read, incremented and written back in turn.
// A cell word with tlast then starts a plane walk over max(L, highest counted label + 1) labels, where
// L is num_features capped at MAX_LABELS; one read and one write per cycle on each memory.
// A read word passes RD_A, RD_B and RD_C, where it waits for a free output; a clear word zeroes all MAX_LABELS maxima.
// Reset is synchronous; after it a clearing pass over all MAX_LABELS entries zeroes both memories
// and no word is accepted meanwhile. Configuration writes are taken in every cycle.
module per_label_max_plane_area
   import plmpa_pkg::*;
#(
   parameter int MAX_LABELS = 1024,
   parameter int COUNT_BITS = 20
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Input words.
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,  // [9:0] label, rest zero
   input  wire logic [OP_W-1:0]         req_tuser,  // [1:0] operation
   input  wire logic                    req_tlast,  // plane_end
   // Result words.
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   output      logic [RSP_DATA_W-1:0]   rsp_tdata,  // [9:0] label_out, [29:10] largest_cells,
                                                    // [81:30] largest_area, rest zero
   // Configuration writes.
   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_addr,
   input  wire logic [SCALAR_W-1:0]     csr_wdata
);

   localparam int LBL_W   = (MAX_LABELS > 2) ? $clog2(MAX_LABELS) : 1;
   localparam int CNT_W   = $clog2(MAX_LABELS + 1);
   localparam int EXT_W   = (CNT_W > NF_W) ? CNT_W : NF_W;
   localparam int LEXT_W  = (LBL_W > LABEL_W) ? LBL_W : LABEL_W;
   localparam int CEXT_W  = (COUNT_BITS > CELLS_W) ? COUNT_BITS : CELLS_W;
   localparam int PROD_W  = COUNT_BITS + SCALAR_W;
   localparam int PEXT_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LBL_W-1:0]      LAST_IDX  = LBL_W'(MAX_LABELS - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CNT_RD = 4'd1;
   localparam logic [3:0] ST_CNT_WR = 4'd2;
   localparam logic [3:0] ST_WINIT  = 4'd3;
   localparam logic [3:0] ST_WALK   = 4'd4;
   localparam logic [3:0] ST_WTAIL  = 4'd5;
   localparam logic [3:0] ST_RD_A   = 4'd6;
   localparam logic [3:0] ST_RD_B   = 4'd7;
   localparam logic [3:0] ST_RD_C   = 4'd8;
   localparam logic [3:0] ST_CLR    = 4'd9;

   // Control registers.
   logic [3:0]          state_ff, state_in;
   logic [LBL_W-1:0]    idx_ff, idx_in;
   logic                clr_plane_ff, clr_plane_in;
   logic                p_v_ff, p_v_in;
   logic [CNT_W-1:0]    hw_ff, hw_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NF_W-1:0]     nf_ff, nf_in;
   logic [SCALAR_W-1:0] scalar_ff, scalar_in;

   // Payload registers.
   logic [LBL_W-1:0]    addr_ff, addr_in;
   logic [LABEL_W-1:0]  label_ff, label_in;
   logic                last_ff, last_in;
   logic                in_range_ff, in_range_in;
   logic [LBL_W-1:0]    p_idx_ff;
   logic [CNT_W-1:0]    end_ff, end_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [COUNT_BITS-1:0] cells_ff, cells_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Count memories and their registered read data.
   logic [COUNT_BITS-1:0] plane_ff [MAX_LABELS];
   logic [COUNT_BITS-1:0] largest_ff [MAX_LABELS];
   logic [COUNT_BITS-1:0] pl_rd_ff, lg_rd_ff;

   logic                  pl_we, lg_we;
   logic [LBL_W-1:0]      pl_waddr, lg_waddr, rd_addr;
   logic [COUNT_BITS-1:0] pl_wdata, lg_wdata;

   logic                accept;
   logic [LEXT_W-1:0]   req_label_ext;
   logic [LBL_W-1:0]    req_addr;
   logic                req_in_range, req_counted;
   logic [EXT_W-1:0]    nf_ext, limit_ext;
   logic [CNT_W-1:0]    limit_now, end_now;
   logic                walk_last, walk_upd, out_free;
   logic [CEXT_W-1:0]   cells_ext;
   logic [PEXT_W-1:0]   prod_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_label_ext = LEXT_W'(req_tdata[LABEL_W-1:0]);
   assign req_addr      = req_label_ext[LBL_W-1:0];
   assign req_in_range  = EXT_W'(req_tdata[LABEL_W-1:0]) < EXT_W'(MAX_LABELS);
   assign req_counted   = req_in_range
                          && ({1'b0, req_tdata[LABEL_W-1:0]} < nf_ff);

   // The walk updates maxima of nonzero labels below the limit, and it clears every plane count
   // touched since the last walk, which may lie above a lowered limit.
   assign nf_ext    = EXT_W'(nf_ff);
   assign limit_ext = (nf_ext > EXT_W'(MAX_LABELS)) ? EXT_W'(MAX_LABELS) : nf_ext;
   assign limit_now = limit_ext[CNT_W-1:0];
   assign end_now   = (hw_ff > limit_now) ? hw_ff : limit_now;

   assign walk_last = (CNT_W'(idx_ff) + CNT_W'(1)) >= end_ff;
   assign walk_upd  = p_v_ff && (p_idx_ff != '0) && (CNT_W'(p_idx_ff) < limit_ff)
                      && (pl_rd_ff > lg_rd_ff);

   assign rd_addr = (state_ff == ST_WALK) ? idx_ff : addr_ff;

   assign cells_ext = CEXT_W'(cells_ff);
   assign prod_ext  = PEXT_W'(prod_ff);

   always_comb begin
      pl_we    = 1'b0;
      pl_waddr = addr_ff;
      pl_wdata = '0;
      lg_we    = 1'b0;
      lg_waddr = idx_ff;
      lg_wdata = '0;
      if (state_ff == ST_CLR) begin
         pl_we    = clr_plane_ff;
         pl_waddr = idx_ff;
         lg_we    = 1'b1;
      end else if (p_v_ff) begin
         pl_we    = 1'b1;
         pl_waddr = p_idx_ff;
         lg_we    = walk_upd;
         lg_waddr = p_idx_ff;
         lg_wdata = pl_rd_ff;
      end else if (state_ff == ST_CNT_WR) begin
         pl_we    = 1'b1;
         pl_wdata = (pl_rd_ff != COUNT_MAX) ? pl_rd_ff + COUNT_BITS'(1) : pl_rd_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      clr_plane_in = clr_plane_ff;
      p_v_in       = (state_ff == ST_WALK);
      hw_in        = hw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      nf_in        = nf_ff;
      scalar_in    = scalar_ff;
      addr_in      = addr_ff;
      label_in     = label_ff;
      last_in      = last_ff;
      in_range_in  = in_range_ff;
      end_in       = end_ff;
      limit_in     = limit_ff;
      cells_in     = cells_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         if (csr_addr == CSR_NUM_FEATURES) begin
            nf_in = csr_wdata[NF_W-1:0];
         end else if (csr_addr == CSR_AREA_SCALAR) begin
            scalar_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in     = req_addr;
               label_in    = req_tdata[LABEL_W-1:0];
               last_in     = req_tlast;
               in_range_in = req_in_range;
               case (req_tuser)
                  OP_CELL: begin
                     if (req_counted) begin
                        state_in = ST_CNT_RD;
                     end else if (req_tlast) begin
                        state_in = ST_WINIT;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_RD_A;
                  end
                  OP_CLEAR: begin
                     state_in     = ST_CLR;
                     idx_in       = '0;
                     clr_plane_in = 1'b0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            if ((CNT_W'(addr_ff) + CNT_W'(1)) > hw_ff) begin
               hw_in = CNT_W'(addr_ff) + CNT_W'(1);
            end
            state_in = last_ff ? ST_WINIT : ST_IDLE;
         end
         ST_WINIT: begin
            end_in   = end_now;
            limit_in = limit_now;
            idx_in   = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            idx_in = idx_ff + LBL_W'(1);
            if (walk_last) begin
               state_in = ST_WTAIL;
            end
         end
         ST_WTAIL: begin
            hw_in    = '0;
            state_in = ST_IDLE;
         end
         ST_RD_A: begin
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cells_in = in_range_ff ? lg_rd_ff : '0;
            prod_in  = PROD_W'(in_range_ff ? lg_rd_ff : '0) * PROD_W'(scalar_ff);
            state_in = ST_RD_C;
         end
         ST_RD_C: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({prod_ext[AREA_W-1:0],
                                           cells_ext[CELLS_W-1:0], label_ff});
               state_in     = ST_IDLE;
            end
         end
         ST_CLR: begin
            idx_in = idx_ff + LBL_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         idx_ff       <= '0;
         clr_plane_ff <= 1'b1;
         p_v_ff       <= 1'b0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         nf_ff        <= NUM_FEATURES_RST;
         scalar_ff    <= AREA_SCALAR_RST;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_plane_ff <= clr_plane_in;
         p_v_ff       <= p_v_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
         nf_ff        <= nf_in;
         scalar_ff    <= scalar_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      label_ff    <= label_in;
      last_ff     <= last_in;
      in_range_ff <= in_range_in;
      p_idx_ff    <= idx_ff;
      end_ff      <= end_in;
      limit_ff    <= limit_in;
      cells_ff    <= cells_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         plane_ff[pl_waddr] <= pl_wdata;
      end
      pl_rd_ff <= plane_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lg_we) begin
         largest_ff[lg_waddr] <= lg_wdata;
      end
      lg_rd_ff <= largest_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: dv/plmpa_checker.sv
`timescale 1ns / 100ps

module plmpa_checker
   import plmpa_pkg::*;
#(
   parameter int MAX_LABELS = 1024,
   parameter int COUNT_BITS = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [OP_W-1:0]       req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [SCALAR_W-1:0]   csr_wdata,
   output int                         outstanding,
   output int                         fail_count
);

   localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;
   localparam int AREA_LSB = LABEL_W + CELLS_W;
   localparam int PAD_LSB  = LABEL_W + CELLS_W + AREA_W;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [CELLS_W-1:0] cells;
      logic [AREA_W-1:0]  area;
   } readout_type;

   logic [NF_W-1:0]       num_features;
   logic [SCALAR_W-1:0]   area_scalar;
   logic [COUNT_BITS-1:0] plane_count [MAX_LABELS];
   logic [COUNT_BITS-1:0] largest_count [MAX_LABELS];
   readout_type           readout_q [$];

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   // Fold the finished plane into the running maxima; background label 0 is skipped.
   function automatic void close_plane();
      int top_label;
      top_label = (num_features > MAX_LABELS) ? MAX_LABELS : int'(num_features);
      for (int i = 1; i < top_label; i++) begin
         if (plane_count[i] > largest_count[i])
            largest_count[i] = plane_count[i];
      end
      foreach (plane_count[i])
         plane_count[i] = '0;
   endfunction

   function automatic readout_type read_largest(logic [LABEL_W-1:0] lbl);
      readout_type           r;
      logic [COUNT_BITS-1:0] count;
      logic [63:0]           product;
      count   = (lbl < MAX_LABELS) ? largest_count[lbl] : '0;
      r.label = lbl;
      r.cells = CELLS_W'(count);
      product = 64'(count) * 64'(area_scalar);
      r.area  = product[AREA_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [LABEL_W-1:0] lbl,
                                       logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch for label %0d, expected %0d, actual %0d",
                  $time, name, lbl, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      readout_type        want;
      logic [LABEL_W-1:0] lbl;
      if (reset) begin
         num_features = NUM_FEATURES_RST;
         area_scalar  = AREA_SCALAR_RST;
         foreach (plane_count[i])
            plane_count[i] = '0;
         foreach (largest_count[i])
            largest_count[i] = '0;
         readout_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_addr == CSR_NUM_FEATURES)
               num_features = csr_wdata[NF_W-1:0];
            else if (csr_addr == CSR_AREA_SCALAR)
               area_scalar = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            lbl = req_tdata[LABEL_W-1:0];
            case (req_tuser)
               OP_CELL: begin
                  if (lbl < num_features && lbl < MAX_LABELS && plane_count[lbl] != COUNT_SAT)
                     plane_count[lbl] = plane_count[lbl] + 1'b1;
                  if (req_tlast)
                     close_plane();
               end
               OP_READ: readout_q.push_back(read_largest(lbl));
               OP_CLEAR: begin
                  foreach (largest_count[i])
                     largest_count[i] = '0;
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (readout_q.size() == 0) begin
               fail_count++;
               $display("%0t: result word with none expected, expected nothing, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = readout_q.pop_front();
               check_field("label_out", want.label, 64'(want.label),
                           64'(rsp_tdata[LABEL_W-1:0]));
               check_field("largest_cells", want.label, 64'(want.cells),
                           64'(rsp_tdata[AREA_LSB-1:LABEL_W]));
               check_field("largest_area", want.label, 64'(want.area),
                           64'(rsp_tdata[PAD_LSB-1:AREA_LSB]));
               check_field("padding", want.label, 64'(0),
                           64'(rsp_tdata[RSP_DATA_W-1:PAD_LSB]));
            end
         end
      end
      outstanding <= readout_q.size();
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import plmpa_pkg::*;

   localparam int LABELS          = 1024;
   localparam int COUNTS          = 20;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 135;
   // Long enough for a plane walk or a clear to finish after the last result.
   localparam int QUIET_CYCLES    = 2 * LABELS + 64;
   localparam int WATCHDOG_LIMIT  = 20000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [SCALAR_W-1:0]   csr_wdata  = '0;

   int outstanding;
   int fail_count;
   int send_idle   = 0;
   int recv_stall  = 0;
   int idle_cycles = 0;

   logic [NF_W-1:0]    nf_now = NUM_FEATURES_RST;
   logic [LABEL_W-1:0] hot_label [4];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   per_label_max_plane_area #(
      .MAX_LABELS(LABELS),
      .COUNT_BITS(COUNTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   plmpa_checker #(
      .MAX_LABELS(LABELS),
      .COUNT_BITS(COUNTS)
   ) scoreboard (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .outstanding(outstanding),
      .fail_count(fail_count)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] lbl,
                            input logic last);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'(lbl);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SCALAR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Let every pending readout arrive, then give a walk or clear time to finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Labels lean on a few hot ones so that counts build up across planes.
   function automatic logic [LABEL_W-1:0] pick_label();
      int r;
      int near;
      r = $urandom_range(0, 99);
      near = int'(nf_now) - 1 + int'($urandom_range(0, 1));
      if (r < 45)
         return hot_label[$urandom_range(0, 3)];
      else if (r < 55)
         return '0;
      else if (r < 65)
         return LABEL_W'(near);
      else if (r < 72)
         return '1;
      else
         return LABEL_W'($urandom_range(0, LABELS - 1));
   endfunction

   initial begin : stimulus
      int sent;
      int n;
      int r;
      int span;
      logic [NF_W-1:0]     nf_next;
      logic [SCALAR_W-1:0] scalar_next;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings.
      send_word(OP_CELL, 10'd0, 1'b0);
      send_word(OP_CELL, 10'h3FF, 1'b0);
      send_word(OP_CELL, 10'h3FF, 1'b0);
      send_word(OP_CELL, 10'd5, 1'b0);
      send_word(OP_CELL, 10'h2AA, 1'b0);
      send_word(OP_CELL, 10'h155, 1'b1);
      send_word(OP_READ, 10'd0, 1'b0);
      send_word(OP_READ, 10'h3FF, 1'b0);
      send_word(OP_READ, 10'd5, 1'b0);
      send_word(OP_READ, 10'h155, 1'b1);
      // A clear wipes the maxima but leaves the open plane counting.
      send_word(OP_CELL, 10'd7, 1'b0);
      send_word(OP_CELL, 10'd7, 1'b0);
      send_word(OP_CLEAR, 10'h2AA, 1'b1);
      send_word(OP_UNUSED, 10'h3FF, 1'b1);
      send_word(OP_CELL, 10'd7, 1'b1);
      send_word(OP_READ, 10'd7, 1'b0);
      send_word(OP_READ, 10'h3FF, 1'b0);
      send_word(OP_CELL, 10'h3FF, 1'b1);
      send_word(OP_READ, 10'h3FF, 1'b0);
      send_word(OP_READ, 10'h2AA, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin
               nf_next = 11'd1024;
               scalar_next = '1;
            end
            1: begin
               nf_next = 11'd1;
               scalar_next = 32'd1;
            end
            2: begin
               nf_next = '1;
               scalar_next = '0;
            end
            3: begin
               nf_next = 11'd13;
               scalar_next = $urandom;
            end
            4: begin
               nf_next = '0;
               scalar_next = AREA_SCALAR_RST;
            end
            5: begin
               nf_next = 11'd1023;
               scalar_next = $urandom;
            end
            6: begin
               nf_next = NF_W'($urandom_range(2, LABELS));
               scalar_next = $urandom;
            end
            default: begin
               nf_next = 11'd2;
               scalar_next = '1;
            end
         endcase
         write_reg(CSR_NUM_FEATURES, SCALAR_W'(nf_next));
         write_reg(CSR_AREA_SCALAR, scalar_next);
         nf_now = nf_next;

         case (phase % 4)
            0: begin
               send_idle = 0;
               recv_stall = 0;
            end
            1: begin
               send_idle = 59;
               recv_stall = 0;
            end
            2: begin
               send_idle = 0;
               recv_stall = 59;
            end
            default: begin
               send_idle = 16;
               recv_stall = 16;
            end
         endcase

         span = (nf_now > LABELS) ? LABELS : int'(nf_now);
         foreach (hot_label[i])
            hot_label[i] = (span > 1) ? LABEL_W'($urandom_range(1, span - 1))
                                      : LABEL_W'($urandom_range(0, LABELS - 1));

         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               send_word(OP_CLEAR, LABEL_W'($urandom), 1'($urandom));
               sent++;
            end else if (r < 6) begin
               send_word(OP_UNUSED, LABEL_W'($urandom), 1'($urandom));
            end else if (r < 30) begin
               send_word(OP_READ, pick_label(), 1'($urandom));
               sent++;
            end else begin
               // One plane of cells; now and then it runs on without its end mark.
               n = $urandom_range(1, 24);
               for (int k = 1; k <= n; k++)
                  send_word(OP_CELL, pick_label(), (k == n) && ($urandom_range(0, 99) < 90));
               sent += n;
            end
         end
      end

      drain();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
hdl/plmpa_pkg.sv
hdl/per_label_max_plane_area.sv
dv/plmpa_checker.sv
dv/tb_top.sv
